/* src/tti_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_pkg: shared definitions for the text to integer converter
// Field widths, register indexes, character codes and the status bundle
// passed from the configuration block to the parser, and character class tests.
// ---------------------------------------------------------------------------
package tti_pkg;

	localparam int CH_W         = 8;
	localparam int VALUE_W      = 32;
	localparam int BASE_LEN_W   = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int ALPHA_BYTES  = CFG_DATA_W / CH_W;
	localparam int MAX_BASE_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIGITS_LOW  = 2'd0,
		CFG_DIGITS_HIGH = 2'd1,
		CFG_BASE_LENGTH = 2'd2
	} cfg_idx_t;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [BASE_LEN_W-1:0] radix;
		logic                  ok;
	} alpha_stat_t;

	function automatic logic is_space(input logic [CH_W-1:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

	function automatic logic is_sign(input logic [CH_W-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

endpackage

/* src/tti_ch_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_ch_if: character channel
// One character per beat with a valid and ready handshake.
// ---------------------------------------------------------------------------
interface tti_ch_if import tti_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, ch, input ready);
	modport sink   (input valid, ch, output ready);
endinterface

/* src/tti_res_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_res_if: result channel
// One parsed integer and the alphabet status per beat.
// ---------------------------------------------------------------------------
interface tti_res_if import tti_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      base_ok;

	modport source (output valid, value, base_ok, input ready);
	modport sink   (input valid, value, base_ok, output ready);
endinterface

/* src/tti_cfg_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_cfg_if: configuration write channel
// A register index and its write data per beat.
// ---------------------------------------------------------------------------
interface tti_cfg_if import tti_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* src/tti_cfg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_cfg: alphabet registers and validity check
// Holds the digit alphabet and the radix, and registers whether the
// alphabet in use is a legal one.
// ---------------------------------------------------------------------------
module tti_cfg import tti_pkg::*; #(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tti_cfg_if.sink                      cfg,
	output logic [MAX_BASE-1:0][CH_W-1:0] alpha,
	output alpha_stat_t                  stat
);

	localparam int LOW_N  = (MAX_BASE < ALPHA_BYTES) ? MAX_BASE : ALPHA_BYTES;
	localparam int HIGH_N = MAX_BASE - LOW_N;

	logic [MAX_BASE-1:0][CH_W-1:0] alpha_q;
	logic [BASE_LEN_W-1:0]         radix_q;
	logic                          ok_q;
	logic                          ok_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			radix_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			ok_q <= ok_c;
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_DIGITS_LOW: begin
						for (int k = 0; k < LOW_N; k++)
							alpha_q[k] <= cfg.data[CH_W*k +: CH_W];
					end
					CFG_DIGITS_HIGH: begin
						for (int k = 0; k < HIGH_N; k++)
							alpha_q[LOW_N+k] <= cfg.data[CH_W*k +: CH_W];
					end
					CFG_BASE_LENGTH: begin
						radix_q <= cfg.data[BASE_LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Each digit in use must be unique and not NUL, a sign or whitespace.
	always_comb begin
		ok_c = (radix_q >= BASE_LEN_W'(2)) && (radix_q <= BASE_LEN_W'(MAX_BASE));
		for (int i = 0; i < MAX_BASE; i++) begin
			if (BASE_LEN_W'(i) < radix_q) begin
				if ((alpha_q[i] == CH_NUL) || is_sign(alpha_q[i]) || is_space(alpha_q[i]))
					ok_c = 1'b0;
				for (int j = i + 1; j < MAX_BASE; j++) begin
					if ((BASE_LEN_W'(j) < radix_q) && (alpha_q[j] == alpha_q[i]))
						ok_c = 1'b0;
				end
			end
		end
	end

	assign alpha      = alpha_q;
	assign stat.radix = radix_q;
	assign stat.ok    = ok_q;

endmodule

/* src/tti_parse.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tti_parse: character register, parser state and result register
// Each registered character may update the phase, sign and accumulator when it is consumed;
// the terminator loads the result register.
// ---------------------------------------------------------------------------
module tti_parse import tti_pkg::*; #(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tti_ch_if.sink                        chars,
	tti_res_if.source                     result,
	input  logic [MAX_BASE-1:0][CH_W-1:0] alpha,
	input  alpha_stat_t                   stat
);

	localparam int IDX_W = $clog2(MAX_BASE);

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	logic                      valid_s1;
	logic [CH_W-1:0]           ch_s1;
	phase_t                    phase_q;
	logic                      neg_q;
	logic [VALUE_W-1:0]        acc_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_ok_q;

	logic                      out_free;
	logic                      is_term;
	logic                      s1_fire;
	logic [MAX_BASE-1:0]       match;
	logic                      hit;
	logic [IDX_W-1:0]          idx;
	logic [VALUE_W-1:0]        digit;
	logic [VALUE_W-1:0]        term;
	logic [VALUE_W-1:0]        prod;
	logic [VALUE_W-1:0]        mac;

	assign out_free    = !out_valid_q || result.ready;
	assign is_term     = (ch_s1 == CH_NUL);
	// Only a terminator needs room in the result register.
	assign s1_fire     = valid_s1 && (!is_term || out_free);
	assign chars.ready = !valid_s1 || s1_fire;

	always_comb begin
		for (int k = 0; k < MAX_BASE; k++)
			match[k] = (BASE_LEN_W'(k) < stat.radix) && (alpha[k] == ch_s1);
	end

	// The lowest matching position wins when the alphabet repeats a character.
	always_comb begin
		idx = '0;
		for (int k = MAX_BASE - 1; k >= 0; k--) begin
			if (match[k])
				idx = IDX_W'(k);
		end
	end

	assign hit   = |match;
	assign digit = VALUE_W'(idx);
	assign term  = neg_q ? (VALUE_W'(0) - digit) : digit;
	assign prod  = acc_q * VALUE_W'(stat.radix);
	assign mac   = prod + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ch_s1       <= '0;
			phase_q     <= PH_SPACE;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_ok_q    <= 1'b0;
		end else begin
			if (chars.ready) begin
				valid_s1 <= chars.valid;
				ch_s1    <= chars.ch;
			end
			if (result.ready)
				out_valid_q <= 1'b0;
			if (s1_fire) begin
				if (is_term) begin
					out_valid_q <= 1'b1;
					out_value_q <= stat.ok ? $signed(acc_q) : '0;
					out_ok_q    <= stat.ok;
					phase_q     <= PH_SPACE;
					neg_q       <= 1'b0;
					acc_q       <= '0;
				end else if (!((phase_q == PH_SPACE) && is_space(ch_s1))) begin
					if (((phase_q == PH_SPACE) || (phase_q == PH_SIGN)) && is_sign(ch_s1)) begin
						if (ch_s1 == CH_MINUS)
							neg_q <= !neg_q;
						phase_q <= PH_SIGN;
					end else if (phase_q != PH_STOP) begin
						if (hit) begin
							acc_q   <= mac;
							phase_q <= PH_DIGITS;
						end else begin
							phase_q <= PH_STOP;
						end
					end
				end
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.value   = out_value_q;
	assign result.base_ok = out_ok_q;

endmodule

/* src/text_to_integer_any_base_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_to_integer_any_base_top: streaming string to integer converter
// Parses a character stream against a configurable digit alphabet and
// returns one signed 32-bit value per zero-terminated string.
// ---------------------------------------------------------------------------
// Usage:
// Characters arrive one per beat on the chars channel. Leading whitespace is
// skipped, a run of plus and minus signs sets the sign, and alphabet
// characters are accumulated in the configured radix with 32-bit wrap. The
// first character outside the alphabet freezes the value. A zero character
// ends the string and produces one beat on the result channel; no other
// character produces a result.
// The cfg channel writes the alphabet (digits_low, digits_high) and the
// radix (base_length); it is always ready. The user must write it only while
// idle; the block itself does not enforce this.
// One character is accepted every cycle: the character register feeds a
// parallel compare, multiply and add into the accumulator. When the receiver
// stalls, the result register holds its beat and characters still flow until
// a second terminator meets the full result register.
// Reset clears the parser state, the result register and all configuration
// registers, so the alphabet reads as invalid until it is written.
// ---------------------------------------------------------------------------
module text_to_integer_any_base_top import tti_pkg::*; #(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tti_ch_if.sink     chars,
	tti_res_if.source  result,
	tti_cfg_if.sink    cfg
);

	logic [MAX_BASE-1:0][CH_W-1:0] alpha;
	alpha_stat_t                   stat;

	tti_cfg #(
		.MAX_BASE (MAX_BASE)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.alpha  (alpha),
		.stat   (stat)
	);

	tti_parse #(
		.MAX_BASE (MAX_BASE)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result),
		.alpha  (alpha),
		.stat   (stat)
	);

	// With the result register empty, nothing may hold back the character stream.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> chars.ready)
		else $error("character channel stalled with an empty result register");

	a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.base_ok) |-> (result.value == '0))
		else $error("invalid alphabet produced a non-zero value");

	// The registered check must agree with the radix it was computed from.
	a_ok_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ok |-> (($past(stat.radix) >= BASE_LEN_W'(2)) &&
			($past(stat.radix) <= BASE_LEN_W'(MAX_BASE))))
		else $error("alphabet flagged valid with an out-of-range radix");

endmodule

/* bench/tb_text_to_integer_any_base_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_to_integer_any_base_top: self-checking bench for the converter
// A short table of directed strings over fixed alphabets is followed by
// rounds of random strings, each round under a fresh alphabet and radix and
// one of four idling patterns. A parser model in the bench predicts each
// terminator's result, and every result beat is checked against the oldest
// prediction. One round holds the result channel off for a long stretch so
// that the converter fills up and stalls the character channel.
// ---------------------------------------------------------------------------
module tb_text_to_integer_any_base_top;
	import tti_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int MAX_BASE      = MAX_BASE_DEF;
	localparam int ITEM_TARGET   = 1400;
	localparam int ROUND_CHARS   = 100;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_MAX    = 10;
	localparam int DIR_ROWS      = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Alphabets, lowest byte holds digit 0.
	localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
	localparam logic [63:0] HEX_HI = 64'h6665_6463_6261_3938;
	localparam logic [63:0] BIN_LO = 64'h0000_0000_0000_3130;

	typedef enum logic [1:0] {
		PH_BLANKS,
		PH_SIGNS,
		PH_DIGITS,
		PH_HALTED
	} parse_phase_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      base_ok;
	} parse_result_t;

	typedef struct {
		logic [63:0]           lo;
		logic [63:0]           hi;
		logic [BASE_LEN_W-1:0] len;
		string                 text;
		bit                    known;
		int                    value;
		bit                    ok;
	} dir_row_t;

	// Each row is sent followed by a terminator. Where known is set, the
	// result is the one written in the row.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{64'h0,  64'h0,  5'd0,  "1",      1'b1, 0,   1'b0},
		'{DEC_LO, DEC_HI, 5'd10, "\t -12", 1'b1, -12, 1'b1},
		'{DEC_LO, DEC_HI, 5'd10, "- 5",    1'b1, 0,   1'b1},
		'{DEC_LO, DEC_HI, 5'd10, "",       1'b1, 0,   1'b1},
		'{DEC_LO, HEX_HI, 5'd16, "-f",     1'b1, -15, 1'b1},
		'{BIN_LO, 64'h0,  5'd2,  "-101",   1'b0, 0,   1'b0},
		'{BIN_LO, 64'h0,  5'd1,  "1",      1'b1, 0,   1'b0},
		'{DEC_LO, HEX_HI, 5'd17, "\377",   1'b1, 0,   1'b0},
		'{64'h3130_3130, 64'h0, 5'd4, "1", 1'b1, 0,   1'b0},
		'{64'h2B30, 64'h0, 5'd2, "0",      1'b1, 0,   1'b0},
		'{64'h0930, 64'h0, 5'd2, "0",      1'b1, 0,   1'b0},
		'{64'h0030, 64'h0, 5'd2, "0",      1'b1, 0,   1'b0}
	};

	logic clk;
	logic arst_n;

	tti_ch_if  chars_if ();
	tti_res_if res_if ();
	tti_cfg_if cfg_if ();

	text_to_integer_any_base_top #(
		.MAX_BASE (MAX_BASE)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.result (res_if.source),
		.cfg    (cfg_if.sink)
	);

	// Parser model state and its copy of the registers.
	logic [63:0]           digits_lo;
	logic [63:0]           digits_hi;
	logic [BASE_LEN_W-1:0] radix;
	parse_phase_t          parse_phase;
	bit                    negate;
	logic [VALUE_W-1:0]    acc;

	parse_result_t pending_results [$];
	int            mismatches;
	int            chars_sent;
	int            send_idle_pct;
	int            recv_stall_pct;
	bit            holding;
	event          hold_off_go;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit blank_char(input logic [CH_W-1:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

	function automatic bit bad_glyph(input logic [CH_W-1:0] c);
		return (c == CH_NUL) || (c == CH_PLUS) || (c == CH_MINUS) || blank_char(c);
	endfunction

	function automatic logic [CH_W-1:0] glyph_of(input logic [63:0] lo, input logic [63:0] hi,
		input int k);
		return (k < ALPHA_BYTES) ? lo[CH_W*k +: CH_W] : hi[CH_W*(k-ALPHA_BYTES) +: CH_W];
	endfunction

	function automatic int digit_count();
		return (radix > MAX_BASE) ? MAX_BASE : int'(radix);
	endfunction

	function automatic bit alphabet_valid();
		int n;
		n = int'(radix);
		if ((n < 2) || (n > MAX_BASE))
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			if (bad_glyph(glyph_of(digits_lo, digits_hi, i)))
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (glyph_of(digits_lo, digits_hi, j) == glyph_of(digits_lo, digits_hi, i))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advances the parser by one character; a terminator yields a result.
	function automatic void advance_parser(input logic [CH_W-1:0] c, output bit emits,
		output parse_result_t res);
		int                 n;
		bit                 found;
		logic [VALUE_W-1:0] digit;
		emits = 1'b0;
		res   = '0;
		found = 1'b0;
		digit = '0;
		if (c == CH_NUL) begin
			emits = 1'b1;
			if (alphabet_valid()) begin
				res.value   = acc;
				res.base_ok = 1'b1;
			end
			parse_phase = PH_BLANKS;
			negate      = 1'b0;
			acc         = '0;
		end else if (!(parse_phase == PH_BLANKS && blank_char(c))) begin
			if ((parse_phase == PH_BLANKS || parse_phase == PH_SIGNS) &&
				(c == CH_PLUS || c == CH_MINUS)) begin
				if (c == CH_MINUS)
					negate = !negate;
				parse_phase = PH_SIGNS;
			end else if (parse_phase != PH_HALTED) begin
				n = digit_count();
				for (int k = 0; k < n; k++) begin
					if (!found && glyph_of(digits_lo, digits_hi, k) == c) begin
						found = 1'b1;
						digit = k;
					end
				end
				if (found) begin
					acc         = acc * radix + (negate ? (32'd0 - digit) : digit);
					parse_phase = PH_DIGITS;
				end else begin
					parse_phase = PH_HALTED;
				end
			end
		end
	endfunction

	task automatic send_char(input logic [CH_W-1:0] c, input bit fixed,
		input parse_result_t fixed_res);
		bit            emits;
		parse_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= c;
		do @(posedge clk); while (!chars_if.ready);
		advance_parser(c, emits, res);
		if (emits)
			pending_results.push_back(fixed ? fixed_res : res);
		chars_sent++;
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_DIGITS_LOW:  digits_lo = data;
			CFG_DIGITS_HIGH: digits_hi = data;
			CFG_BASE_LENGTH: radix = data[BASE_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_alphabet(input logic [63:0] lo, input logic [63:0] hi,
		input logic [BASE_LEN_W-1:0] len);
		logic [63:0] len_word;
		// Junk above the radix field must be dropped by the block.
		len_word = {$urandom, $urandom};
		len_word[BASE_LEN_W-1:0] = len;
		write_reg(CFG_DIGITS_LOW, lo);
		write_reg(CFG_DIGITS_HIGH, hi);
		write_reg(CFG_BASE_LENGTH, len_word);
		cfg_if.valid <= 1'b0;
	endtask

	// Waits until every expected result has come and the pipeline is empty.
	task automatic settle();
		chars_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] random_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CH_W'(int'(CH_TAB) + k);
	endfunction

	function automatic logic [CH_W-1:0] random_digit(input int n);
		return (n > 0) ? glyph_of(digits_lo, digits_hi, $urandom_range(n - 1))
			: CH_W'($urandom_range(255, 1));
	endfunction

	function automatic logic [CH_W-1:0] random_sign();
		return $urandom_range(1) ? CH_PLUS : CH_MINUS;
	endfunction

	// Sixteen distinct characters that are all legal digits.
	task automatic make_alphabet(output logic [63:0] lo, output logic [63:0] hi);
		logic [CH_W-1:0] glyphs [16];
		logic [CH_W-1:0] g;
		bit              clash;
		for (int k = 0; k < 16; k++) begin
			do begin
				g     = CH_W'($urandom_range(255, 1));
				clash = bad_glyph(g);
				for (int j = 0; j < k; j++)
					if (glyphs[j] == g)
						clash = 1'b1;
			end while (clash);
			glyphs[k] = g;
		end
		for (int k = 0; k < ALPHA_BYTES; k++) begin
			lo[CH_W*k +: CH_W] = glyphs[k];
			hi[CH_W*k +: CH_W] = glyphs[k + ALPHA_BYTES];
		end
	endtask

	task automatic choose_alphabet();
		logic [63:0]           lo;
		logic [63:0]           hi;
		logic [BASE_LEN_W-1:0] len;
		logic [CH_W-1:0]       bad;
		int                    pos;
		make_alphabet(lo, hi);
		len = BASE_LEN_W'($urandom_range(16, 2));
		case ($urandom_range(9))
			0: begin
				lo  = DEC_LO;
				hi  = DEC_HI;
				len = 5'd10;
			end
			1: begin
				lo  = DEC_LO;
				hi  = HEX_HI;
				len = 5'd16;
			end
			2: begin
				lo  = BIN_LO;
				len = 5'd2;
			end
			7: len = $urandom_range(1) ? 5'd2 : 5'd16;
			8: begin
				// A single illegal or repeated character spoils the alphabet.
				pos = $urandom_range(len - 1);
				case ($urandom_range(4))
					0: bad = CH_NUL;
					1: bad = CH_PLUS;
					2: bad = CH_MINUS;
					3: bad = random_blank();
					default: bad = glyph_of(lo, hi, (pos == 0) ? 1 : 0);
				endcase
				if (pos < ALPHA_BYTES)
					lo[CH_W*pos +: CH_W] = bad;
				else
					hi[CH_W*(pos-ALPHA_BYTES) +: CH_W] = bad;
			end
			9: begin
				case ($urandom_range(3))
					0: len = 5'd0;
					1: len = 5'd1;
					2: len = 5'd31;
					default: len = BASE_LEN_W'($urandom_range(30, 17));
				endcase
			end
			default: ;
		endcase
		program_alphabet(lo, hi, len);
	endtask

	// Mostly well-formed strings; the rest is a jumble of character classes,
	// sometimes left unterminated so that it runs into the next string.
	task automatic send_word();
		int              n_used;
		int              n_digits;
		logic [CH_W-1:0] c;
		n_used = digit_count();
		if ($urandom_range(99) < 80) begin
			repeat ($urandom_range(2)) send_char(random_blank(), 1'b0, '0);
			repeat ($urandom_range(3)) send_char(random_sign(), 1'b0, '0);
			n_digits = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
			repeat (n_digits) send_char(random_digit(n_used), 1'b0, '0);
			if ($urandom_range(4) == 0) begin
				send_char(CH_W'($urandom_range(255, 1)), 1'b0, '0);
				repeat ($urandom_range(3)) send_char(random_digit(n_used), 1'b0, '0);
			end
			send_char(CH_NUL, 1'b0, '0);
		end else begin
			repeat ($urandom_range(8)) begin
				case ($urandom_range(3))
					0: c = random_blank();
					1: c = random_sign();
					2: c = random_digit(n_used);
					default: c = CH_W'($urandom_range(255, 1));
				endcase
				send_char(c, 1'b0, '0);
			end
			if ($urandom_range(9) != 0)
				send_char(CH_NUL, 1'b0, '0);
		end
	endtask

	// Result receiver; a long hold-off overrides the random stalls.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_if.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		holding = 1'b0;
		forever begin
			@(hold_off_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result beat: value %0d base_ok %0b",
						res_if.value, res_if.base_ok);
			end else begin
				want = pending_results.pop_front();
				if (res_if.value !== want.value || res_if.base_ok !== want.base_ok) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result mismatch: expected value %0d base_ok %0b, got value %0d base_ok %0b",
							want.value, want.base_ok, res_if.value, res_if.base_ok);
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		parse_result_t fixed_res;
		int            round;
		int            round_end;
		arst_n         = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch    = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.index   = '0;
		cfg_if.data    = '0;
		digits_lo      = '0;
		digits_hi      = '0;
		radix          = '0;
		parse_phase    = PH_BLANKS;
		negate         = 1'b0;
		acc            = '0;
		mismatches     = 0;
		chars_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to the spare index must leave the alphabet invalid.
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_if.valid <= 1'b0;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].lo != digits_lo || directed_rows[r].hi != digits_hi ||
				directed_rows[r].len != radix) begin
				settle();
				program_alphabet(directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].len);
			end
			for (int i = 0; i < directed_rows[r].text.len(); i++)
				send_char(directed_rows[r].text[i], 1'b0, '0);
			fixed_res.value   = directed_rows[r].value;
			fixed_res.base_ok = directed_rows[r].ok;
			send_char(CH_NUL, directed_rows[r].known, fixed_res);
		end

		round = 0;
		while (chars_sent < ITEM_TARGET) begin
			settle();
			choose_alphabet();
			case (round % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct  = 11;
					recv_stall_pct = 11;
				end
			endcase
			// The first round runs flat out against a stalled receiver.
			if (round == 0)
				-> hold_off_go;
			round_end = chars_sent + ROUND_CHARS;
			while (chars_sent < round_end)
				send_word();
			round++;
		end
		settle();

		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
